// File: hdl/civil_utc_to_epoch_ms_macros.svh
// assertion macros for the civil time to epoch milliseconds converter
`ifndef CIVIL_UTC_TO_EPOCH_MS_MACROS_SVH
`define CIVIL_UTC_TO_EPOCH_MS_MACROS_SVH
`ifndef SYNTHESIS
`define CUTM_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");
`define CUTM_ASSERT_DELAY(label, clk, rst_n, a, n, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (b)) \
        else $error("delayed check failed");
`else
`define CUTM_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define CUTM_ASSERT_DELAY(label, clk, rst_n, a, n, b)
`endif
`endif

// File: hdl/cutm_pkg.sv
// shared constants and lookup for the civil time to epoch milliseconds converter
`timescale 1ns / 1ps
package cutm_pkg;

    // year offset that keeps the shifted year non-negative: 82 eras
    localparam int unsigned ERA_BIAS       = 82;
    localparam int unsigned ERA_BIAS_YEARS = ERA_BIAS * 400;

    // floor(u / 400) = (u * RECIP_400) >> 32 for u below 2^17
    localparam logic [23:0] RECIP_400      = 24'd10737419;

    localparam int unsigned DAYS_PER_ERA   = 146097;
    localparam int unsigned EPOCH_DAYS     = 719468;
    localparam int unsigned MS_PER_DAY     = 86400000;
    localparam int unsigned MS_PER_SEC     = 1000;

    localparam int unsigned LATENCY        = 5;

    // days from march 1 to the first of the march-based month
    function automatic logic [8:0] days_before_month(input logic [3:0] mp);
        logic [8:0] d;
        begin
            case (mp)
                4'd0:    d = 9'd0;
                4'd1:    d = 9'd31;
                4'd2:    d = 9'd61;
                4'd3:    d = 9'd92;
                4'd4:    d = 9'd122;
                4'd5:    d = 9'd153;
                4'd6:    d = 9'd184;
                4'd7:    d = 9'd214;
                4'd8:    d = 9'd245;
                4'd9:    d = 9'd275;
                4'd10:   d = 9'd306;
                4'd11:   d = 9'd337;
                4'd12:   d = 9'd367;
                default: d = 9'd0;
            endcase
            return d;
        end
    endfunction

endpackage

// File: hdl/cutm_tod.sv
// time of day in milliseconds, delayed to line up with the day count
`timescale 1ns / 1ps
module cutm_tod
    import cutm_pkg::*;
(
    input  logic        clk,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [5:0]  second,
    input  logic [7:0]  fraction,
    output logic [26:0] tod_ms
);

    logic [16:0] hms_reg;
    logic [16:0] hms_next;
    logic [9:0]  fms_reg;
    logic [9:0]  fms_next;
    logic [17:0] frac_prod;
    logic [26:0] tod_reg;
    logic [26:0] tod_next;
    logic [26:0] tod_d1_reg;
    logic [26:0] tod_d2_reg;

    always_comb
    begin
        hms_next  = 17'({12'd0, hour} * 17'd3600) + 17'({11'd0, minute} * 17'd60)
                  + {11'd0, second};
        frac_prod = {10'd0, fraction} * 18'd1000;
        fms_next  = frac_prod[17:8];
        tod_next  = 27'({10'd0, hms_reg} * 27'(MS_PER_SEC)) + {17'd0, fms_reg};
    end

    always_ff @(posedge clk)
    begin
        hms_reg    <= hms_next;
        fms_reg    <= fms_next;
        tod_reg    <= tod_next;
        tod_d1_reg <= tod_reg;
        tod_d2_reg <= tod_d1_reg;
    end

    assign tod_ms = tod_d2_reg;

endmodule

// File: hdl/cutm_days.sv
// four-stage day count from civil date using 400-year eras
`timescale 1ns / 1ps
`include "civil_utc_to_epoch_ms_macros.svh"
module cutm_days
    import cutm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [15:0] year,
    input  logic [3:0]         month,
    input  logic [4:0]         day,
    output logic               days_valid,
    output logic signed [25:0] days
);

    logic               v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1: march-based year with bias, day of year
    logic signed [16:0] y_shift;
    logic [16:0]        u_next, u1_reg;
    logic [3:0]         mp;
    logic signed [9:0]  doy_next, doy1_reg;

    // stage 2: era through reciprocal multiply
    logic [40:0]        q_prod;
    logic [7:0]         q_next, q2_reg;
    logic [16:0]        u2_reg;
    logic signed [9:0]  doy2_reg;

    // stage 3: year of era and day of era
    logic [16:0]        era_years;
    logic [8:0]         yoe;
    logic [1:0]         cent;
    logic [17:0]        yoe365;
    logic [17:0]        doe_base;
    logic signed [18:0] doe_next, doe3_reg;
    logic signed [8:0]  era_next, era3_reg;

    // stage 4
    logic signed [25:0] days_next, days4_reg;

    always_comb
    begin
        y_shift  = $signed({year[15], year}) - ((month <= 4'd2) ? 17'sd1 : 17'sd0);
        u_next   = $unsigned(y_shift) + 17'(ERA_BIAS_YEARS);
        mp       = (month > 4'd2) ? (month - 4'd3) : (month + 4'd9);
        doy_next = $signed({1'b0, days_before_month(mp)}) + $signed({5'd0, day}) - 10'sd1;

        q_prod   = {24'd0, u1_reg} * {17'd0, RECIP_400};
        q_next   = q_prod[39:32];

        era_years = 17'({9'd0, q2_reg} * 17'd400);
        yoe       = 9'(u2_reg - era_years);
        if (yoe >= 9'd300)
            cent = 2'd3;
        else if (yoe >= 9'd200)
            cent = 2'd2;
        else if (yoe >= 9'd100)
            cent = 2'd1;
        else
            cent = 2'd0;
        yoe365   = 18'({9'd0, yoe} * 18'd365);
        doe_base = yoe365 + {11'd0, yoe[8:2]} - {16'd0, cent};
        doe_next = $signed({1'b0, doe_base}) + 19'(doy2_reg);
        era_next = $signed({1'b0, q2_reg}) - 9'(ERA_BIAS);

        // era is negative before year zero, keep the product signed
        days_next = 26'(era3_reg) * $signed(26'(DAYS_PER_ERA)) + 26'(doe3_reg)
                  - $signed(26'(EPOCH_DAYS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        u1_reg    <= u_next;
        doy1_reg  <= doy_next;
        q2_reg    <= q_next;
        u2_reg    <= u1_reg;
        doy2_reg  <= doy1_reg;
        era3_reg  <= era_next;
        doe3_reg  <= doe_next;
        days4_reg <= days_next;
    end

    assign days_valid = v4_reg;
    assign days       = days4_reg;

    // reciprocal quotient must leave a remainder below one era
    `CUTM_ASSERT_IMPLIES(a_yoe_in_era, clk, rst_n, v2_reg, u2_reg >= era_years && yoe < 9'd400)
    // biased shifted year never exceeds 164 eras
    `CUTM_ASSERT_IMPLIES(a_era_bound, clk, rst_n, v2_reg, q2_reg < 8'd164)

endmodule

// File: hdl/civil_utc_to_epoch_ms.sv
// the start transfer passes the day-count stages and the output register before the done strobe with the result
// throughput: one conversion per cycle; busy is never raised
// the depth is set by the era reciprocal multiply, day count and final day-to-ms multiply
// reset (rst_n, async, active low) clears the valid pipeline; nothing else is kept
// results are shown for one cycle under done and cannot be held off
`timescale 1ns / 1ps
`include "civil_utc_to_epoch_ms_macros.svh"
module civil_utc_to_epoch_ms
    import cutm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] year,
    input  logic [3:0]         month,
    input  logic [4:0]         day,
    input  logic [4:0]         hour,
    input  logic [5:0]         minute,
    input  logic [5:0]         second,
    input  logic [7:0]         fraction,
    output logic               done,
    output logic signed [51:0] utc_ms
);

    logic               accept;
    logic               days_valid;
    logic signed [25:0] days;
    logic [26:0]        tod_ms;
    logic               done_reg;
    logic signed [51:0] ms_reg;
    logic signed [51:0] ms_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    cutm_days u_days (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .year       (year),
        .month      (month),
        .day        (day),
        .days_valid (days_valid),
        .days       (days)
    );

    cutm_tod u_tod (
        .clk      (clk),
        .hour     (hour),
        .minute   (minute),
        .second   (second),
        .fraction (fraction),
        .tod_ms   (tod_ms)
    );

    always_comb
    begin
        ms_next = 52'(days) * $signed(52'(MS_PER_DAY)) + $signed({25'd0, tod_ms});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= days_valid;
    end

    always_ff @(posedge clk)
    begin
        ms_reg <= ms_next;
    end

    assign done   = done_reg;
    assign utc_ms = ms_reg;

    // every transfer yields its result under done
    `CUTM_ASSERT_DELAY(a_start_to_done, clk, rst_n, accept, 5, done)
    // no result without a transfer that started it
    `CUTM_ASSERT_IMPLIES(a_done_has_start, clk, rst_n, done, $past(accept, 5))

endmodule

// File: dv/tb_top.sv
// testbench for the civil utc to epoch milliseconds converter
`timescale 1ns / 1ps
module tb_top;

    localparam longint DAYS_PER_ERA  = 146097;
    localparam longint DAYS_TO_EPOCH = 719468;
    localparam longint SECS_PER_DAY  = 86400;
    localparam int     RANDOM_STAMPS = 400;
    // no random idling for this run of transfers
    localparam int     QUIET_FIRST   = 150;
    localparam int     QUIET_LAST    = 270;

    typedef struct {
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic [7:0]         fraction;
        bit                 drain_first;
    } stamp_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [7:0]         fraction;
    logic               done;
    logic signed [51:0] utc_ms;

    stamp_t             stamps_to_send[$];
    logic signed [51:0] expected_ms[$];
    stamp_t             presented;
    bit                 presented_taken;
    int                 stamps_issued;
    int                 stamps_accepted;
    int                 results_checked;
    int                 mismatch_count;
    int                 drain_pauses;
    int                 directed_count;

    civil_utc_to_epoch_ms dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .year     (year),
        .month    (month),
        .day      (day),
        .hour     (hour),
        .minute   (minute),
        .second   (second),
        .fraction (fraction),
        .done     (done),
        .utc_ms   (utc_ms)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // proleptic gregorian day count with floor eras, then seconds and fraction
    function automatic logic [51:0] epoch_ms_of(stamp_t s);
        longint y, mo, dy, hr, mi, se, fr;
        longint era, yoe, mp, doy, doe, days, ms;
        begin
            y  = s.year;
            mo = s.month;
            dy = s.day;
            hr = s.hour;
            mi = s.minute;
            se = s.second;
            fr = s.fraction;
            if (mo <= 2)
                y = y - 1;
            era  = (y >= 0 ? y : y - 399) / 400;
            yoe  = y - era * 400;
            mp   = (mo > 2) ? mo - 3 : mo + 9;
            doy  = (153 * mp + 2) / 5 + dy - 1;
            doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days = era * DAYS_PER_ERA + doe - DAYS_TO_EPOCH;
            ms   = (days * SECS_PER_DAY + hr * 3600 + mi * 60 + se) * 1000 + (fr * 1000) / 256;
            return ms[51:0];
        end
    endfunction

    function automatic stamp_t stamp(int y, int mo, int dy, int hr, int mi, int se, int fr);
        stamp_t s;
        begin
            s.year        = y[15:0];
            s.month       = mo[3:0];
            s.day         = dy[4:0];
            s.hour        = hr[4:0];
            s.minute      = mi[5:0];
            s.second      = se[5:0];
            s.fraction    = fr[7:0];
            s.drain_first = 1'b0;
            return s;
        end
    endfunction

    function automatic stamp_t random_stamp();
        stamp_t s;
        int     mode;
        int     pick;
        begin
            mode = $urandom_range(99);
            s = stamp($urandom_range(2100, 1900), $urandom_range(12, 1), $urandom_range(31, 1),
                      $urandom_range(23), $urandom_range(59), $urandom_range(60),
                      $urandom_range(255));
            if (mode >= 40)
                s.year = 16'($urandom);
            if (mode >= 70)
            begin
                // any bit pattern, invalid dates included
                s.month  = 4'($urandom);
                s.day    = 5'($urandom);
                s.hour   = 5'($urandom);
                s.minute = 6'($urandom);
                s.second = 6'($urandom);
            end
            if (mode >= 90)
            begin
                pick = $urandom_range(9);
                case (pick)
                    0: s.year = -16'sd32768;
                    1: s.year = 16'sd32767;
                    2: s.year = 16'sd0;
                    3: s.year = -16'sd1;
                    4: s.year = -16'sd400;
                    5: s.year = -16'sd401;
                    6: s.year = 16'sd400;
                    7: s.year = 16'sd1969;
                    8: s.year = 16'sd1970;
                    default: s.year = 16'sd2000;
                endcase
                s.month = $urandom_range(3) == 0 ? 4'd2 : s.month;
            end
            s.drain_first = ($urandom_range(49) == 0);
            return s;
        end
    endfunction

    // feeds one timestamp per transfer; idles at random outside the quiet run and before a stamp that waits for a drain
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || presented_taken)
        begin
            presented_taken = 1'b0;
            if (stamps_to_send.size() == 0)
                start <= 1'b0;
            else if (stamps_to_send[0].drain_first && expected_ms.size() != 0)
                start <= 1'b0;
            else if (!(stamps_issued >= QUIET_FIRST && stamps_issued < QUIET_LAST)
                     && $urandom_range(99) < 9)
                start <= 1'b0;
            else
            begin
                presented = stamps_to_send.pop_front();
                if (presented.drain_first)
                    drain_pauses++;
                stamps_issued++;
                year     <= presented.year;
                month    <= presented.month;
                day      <= presented.day;
                hour     <= presented.hour;
                minute   <= presented.minute;
                second   <= presented.second;
                fraction <= presented.fraction;
                start    <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_ms.push_back(epoch_ms_of(presented));
                presented_taken = 1'b1;
                stamps_accepted++;
            end
            if (done)
            begin
                if (expected_ms.size() == 0)
                begin
                    $error("utc_ms result with nothing expected: actual %0d", utc_ms);
                    mismatch_count++;
                end
                else
                begin
                    if (utc_ms !== expected_ms[0])
                    begin
                        $error("utc_ms mismatch: expected %0d actual %0d",
                               expected_ms[0], utc_ms);
                        mismatch_count++;
                    end
                    void'(expected_ms.pop_front());
                    results_checked++;
                end
            end
        end
    end

    initial
    begin
        stamp_t s;
        rst_n           = 1'b0;
        start           = 1'b0;
        year            = '0;
        month           = '0;
        day             = '0;
        hour            = '0;
        minute          = '0;
        second          = '0;
        fraction        = '0;
        presented_taken = 1'b0;
        stamps_issued   = 0;
        stamps_accepted = 0;
        results_checked = 0;
        mismatch_count  = 0;
        drain_pauses    = 0;

        // extremes, the epoch itself, era edges, leap cases and invalid dates
        stamps_to_send.push_back(stamp(1970, 1, 1, 0, 0, 0, 0));
        stamps_to_send.push_back(stamp(1969, 12, 31, 23, 59, 59, 255));
        stamps_to_send.push_back(stamp(-32768, 0, 0, 0, 0, 0, 0));
        stamps_to_send.push_back(stamp(32767, 15, 31, 31, 63, 63, 255));
        stamps_to_send.push_back(stamp(-32768, 15, 31, 31, 63, 63, 255));
        stamps_to_send.push_back(stamp(32767, 0, 0, 0, 0, 0, 0));
        stamps_to_send.push_back(stamp(2016, 12, 31, 23, 59, 60, 128));
        stamps_to_send.push_back(stamp(2000, 2, 29, 12, 0, 0, 1));
        stamps_to_send.push_back(stamp(1900, 2, 29, 0, 0, 0, 0));
        stamps_to_send.push_back(stamp(2023, 4, 31, 6, 30, 15, 64));
        stamps_to_send.push_back(stamp(2024, 0, 15, 1, 2, 3, 4));
        stamps_to_send.push_back(stamp(2024, 13, 1, 0, 0, 0, 0));
        stamps_to_send.push_back(stamp(2024, 14, 10, 0, 0, 0, 0));
        stamps_to_send.push_back(stamp(2024, 15, 20, 0, 0, 0, 0));
        stamps_to_send.push_back(stamp(2024, 3, 0, 0, 0, 0, 0));
        stamps_to_send.push_back(stamp(2024, 1, 0, 0, 0, 0, 0));
        stamps_to_send.push_back(stamp(0, 3, 1, 0, 0, 0, 0));
        stamps_to_send.push_back(stamp(-1, 3, 1, 0, 0, 0, 0));
        stamps_to_send.push_back(stamp(-400, 2, 28, 0, 0, 0, 0));
        stamps_to_send.push_back(stamp(-401, 3, 1, 0, 0, 0, 0));
        stamps_to_send.push_back(stamp(1600, 3, 1, 0, 0, 0, 0));
        stamps_to_send.push_back(stamp(2400, 2, 29, 23, 59, 59, 255));
        stamps_to_send.push_back(stamp(1999, 7, 4, 31, 63, 63, 3));
        directed_count = stamps_to_send.size();

        for (int i = 0; i < RANDOM_STAMPS; i++)
        begin
            s = random_stamp();
            // the first random stamp waits for the directed results to drain
            if (i == 0)
                s.drain_first = 1'b1;
            stamps_to_send.push_back(s);
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (stamps_to_send.size() != 0 || start)
            @(negedge clk);
        while (expected_ms.size() != 0)
            @(negedge clk);
        repeat (4 * cutm_pkg::LATENCY) @(negedge clk);

        $display("converted %0d timestamps (%0d directed), checked %0d results",
                 stamps_accepted, directed_count, results_checked);
        $display("sender paused for a full drain %0d times", drain_pauses);
        if (mismatch_count == 0 && expected_ms.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", expected_ms.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/cutm_pkg.sv
hdl/cutm_tod.sv
hdl/cutm_days.sv
hdl/civil_utc_to_epoch_ms.sv
dv/tb_top.sv
